### sv/b2d256_pkg.sv
// Shared constants for the 256-bit binary to decimal converter.
// No dependencies.
`timescale 1ns / 1ps

package b2d256_pkg;

  // Width of one input limb.
  localparam int unsigned LimbW = 64;

  // Width of one BCD digit.
  localparam int unsigned DigitW = 4;

  // Smallest digit that needs the add-three correction before a shift.
  localparam logic [DigitW-1:0] DabbleMin = 4'd5;

  // Amount added to a digit that is five or more.
  localparam logic [DigitW-1:0] DabbleAdd = 4'd3;

endpackage

### sv/binary_to_decimal_256_top.sv
// Top level of the binary to decimal converter: limb collection, bit-serial
// double-dabble conversion, leading-zero trim and digit-pair emission.
// Depends on b2d256_pkg.
`timescale 1ns / 1ps

//  channel | direction | beat fields                                    | handshake
//  --------+-----------+------------------------------------------------+----------------------
//  in      | input     | limb_i, last_limb_i                            | in_valid_i/in_ready_o
//  out     | output    | high_digit_o, low_digit_o, pair_full_o,        | out_valid_o/out_ready_i
//          |           | last_pair_o                                    |
//
// A limb without the last flag is shifted into the limb register. The last limb
// starts a conversion of all LIMB_COUNT*64 value bits, one value bit shifted into
// the BCD register per cycle, followed by a trim that strips up to MAX_DIGITS-1
// leading zero digits, one digit a cycle, its last step handing over to emission.
// Pairs then leave at one per cycle while the output is taken. Input is
// accepted only between conversions.
// Reset clears the limb register and all control state. A stalled output
// holds its beat and pauses the emission.

module binary_to_decimal_256_top
  import b2d256_pkg::*;
#(
  parameter int unsigned LIMB_COUNT = 4,
  parameter int unsigned MAX_DIGITS = 78
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [LimbW-1:0]  limb_i,
  input  logic              last_limb_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DigitW-1:0] high_digit_o,
  output logic [DigitW-1:0] low_digit_o,
  output logic              pair_full_o,
  output logic              last_pair_o
);

  localparam int unsigned VW = LIMB_COUNT * LimbW;
  localparam int unsigned BW = MAX_DIGITS * DigitW;
  localparam int unsigned CW = $clog2(VW);
  localparam int unsigned RW = $clog2(MAX_DIGITS + 1);
  localparam logic [CW-1:0] LastBit = CW'(VW - 1);
  localparam logic [CW-1:0] OneBit = CW'(1);
  localparam logic [RW-1:0] AllDigits = RW'(MAX_DIGITS);
  localparam logic [RW-1:0] OneDigit = RW'(1);
  localparam logic [RW-1:0] TwoDigits = RW'(2);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_TRIM,
    S_EMIT
  } state_e;

  state_e            state_q;
  logic [VW-1:0]     value_q;
  logic [BW-1:0]     bcd_q;
  logic              ovf_q;
  logic [CW-1:0]     bit_cnt_q;
  logic [RW-1:0]     remain_q;
  logic              out_valid_q;
  logic [DigitW-1:0] high_digit_q;
  logic [DigitW-1:0] low_digit_q;
  logic              pair_full_q;
  logic              last_pair_q;

  logic [BW-1:0]     bcd_adj;
  logic [BW-1:0]     bcd_shift;
  logic [DigitW-1:0] top_digit;
  logic [DigitW-1:0] next_digit;
  logic              in_fire;
  logic              slot_free;
  logic [RW-1:0]     remain_next;

  // Add-three correction on every digit, then the whole register shifts
  // left by one bit, taking the next value bit at the bottom.
  always_comb begin
    logic [DigitW-1:0] dig;
    dig = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      dig = bcd_q[DigitW*i +: DigitW];
      bcd_adj[DigitW*i +: DigitW] = (dig >= DabbleMin) ? dig + DabbleAdd : dig;
    end
  end

  assign bcd_shift = {bcd_adj[BW-2:0], value_q[VW-1]};

  // The two most significant digits still to be sent.
  assign top_digit  = bcd_q[BW-1 -: DigitW];
  assign next_digit = bcd_q[BW-DigitW-1 -: DigitW];

  // An odd count sends a single digit first, after that two at a time.
  assign remain_next = remain_q - (remain_q[0] ? OneDigit : TwoDigits);

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  // Sequencer, datapath registers and output beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      value_q      <= '0;
      bcd_q        <= '0;
      ovf_q        <= 1'b0;
      bit_cnt_q    <= '0;
      remain_q     <= '0;
      out_valid_q  <= 1'b0;
      high_digit_q <= '0;
      low_digit_q  <= '0;
      pair_full_q  <= 1'b0;
      last_pair_q  <= 1'b0;
    end else begin
      // Outside emission a taken beat empties the output register; during
      // emission the emitter decides its next value.
      if (out_valid_q && out_ready_i && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            value_q <= VW'({value_q, limb_i});
            if (last_limb_i) begin
              bcd_q     <= '0;
              ovf_q     <= 1'b0;
              bit_cnt_q <= LastBit;
              state_q   <= S_CONV;
            end
          end
        end
        S_CONV: begin
          // A bit leaving the top digit means more digits than the store holds.
          bcd_q     <= bcd_shift;
          ovf_q     <= ovf_q | bcd_adj[BW-1];
          value_q   <= value_q << 1;
          bit_cnt_q <= bit_cnt_q - OneBit;
          if (bit_cnt_q == '0) begin
            remain_q <= AllDigits;
            state_q  <= S_TRIM;
          end
        end
        S_TRIM: begin
          // Drop leading zeros, keeping at least one digit.
          if (!ovf_q && (top_digit == '0) && (remain_q > OneDigit)) begin
            bcd_q    <= bcd_q << DigitW;
            remain_q <= remain_q - OneDigit;
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            last_pair_q <= (remain_next == '0);
            remain_q    <= remain_next;
            if (remain_q[0]) begin
              high_digit_q <= '0;
              low_digit_q  <= top_digit;
              pair_full_q  <= 1'b0;
              bcd_q        <= bcd_q << DigitW;
            end else begin
              high_digit_q <= top_digit;
              low_digit_q  <= next_digit;
              pair_full_q  <= 1'b1;
              bcd_q        <= bcd_q << (2 * DigitW);
            end
            if (remain_next == '0) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign high_digit_o = high_digit_q;
  assign low_digit_o  = low_digit_q;
  assign pair_full_o  = pair_full_q;
  assign last_pair_o  = last_pair_q;

endmodule

### tb/tb_top.sv
// Self-checking testbench for binary_to_decimal_256_top: limb beats in, digit-pair beats out.
// It predicts the decimal digits of every value and compares them with the pairs that come out.
// Depends on b2d256_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb_top;
  import b2d256_pkg::*;

  localparam int unsigned LIMBS       = 4;
  localparam int unsigned DIGITS_MAX  = 78;
  localparam int unsigned ValW        = LIMBS * LimbW;
  localparam int unsigned ITEM_TARGET = 360;
  localparam int unsigned CALM_FROM   = 300;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE      = 400;

  // One output beat: a pair of digits with its flags.
  typedef struct packed {
    logic [DigitW-1:0] hi;
    logic [DigitW-1:0] lo;
    logic              full;
    logic              fin;
  } digit_pair_t;

  // One row of the directed table; a typed pair replaces the prediction when given.
  typedef struct {
    logic [LimbW-1:0] limb;
    logic             last;
    bit               typed;
    digit_pair_t      pair;
  } limb_row_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [LimbW-1:0]  limb_i      = '0;
  logic              last_limb_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [DigitW-1:0] high_digit_o;
  logic [DigitW-1:0] low_digit_o;
  logic              pair_full_o;
  logic              last_pair_o;

  logic [ValW-1:0] limb_shift = '0;
  digit_pair_t     expected_pairs [$];
  limb_row_t       limb_table [$];
  int unsigned     mismatches  = 0;
  int unsigned     cycle_count = 0;
  int unsigned     idle_pct    = 30;
  int unsigned     stall_left  = 0;
  int unsigned     limbs_sent  = 0;
  digit_pair_t     got_pair;
  digit_pair_t     want_pair;

  binary_to_decimal_256_top #(
    .LIMB_COUNT(LIMBS),
    .MAX_DIGITS(DIGITS_MAX)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .limb_i      (limb_i),
    .last_limb_i (last_limb_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .high_digit_o(high_digit_o),
    .low_digit_o (low_digit_o),
    .pair_full_o (pair_full_o),
    .last_pair_o (last_pair_o)
  );

  // Clock with a 10 ns period.
  always #5 clk_i = ~clk_i;

  // Watchdog: a run that hangs is a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Shift one limb into the value and, on the last limb, work out the digit pairs,
  // most significant first with leading zeros dropped.
  task automatic convert_limb(input logic [LimbW-1:0] limb, input logic last,
                              output digit_pair_t pairs [$]);
    logic [ValW-1:0]   val;
    logic [ValW-1:0]   rem;
    logic [DigitW-1:0] digits [DIGITS_MAX];
    int                n;
    int                pos;
    digit_pair_t       p;
    pairs = {};
    limb_shift = {limb_shift[ValW-LimbW-1:0], limb};
    if (last) begin
      val = limb_shift;
      n = 0;
      do begin
        rem = val % 10;
        digits[n] = rem[DigitW-1:0];
        val = val / 10;
        n++;
      end while (val != 0 && n < DIGITS_MAX);
      limb_shift = '0;
      pos = n;
      // An odd count leaves a lone leading digit in the first beat.
      if (n % 2 == 1) begin
        pos--;
        p.hi   = '0;
        p.lo   = digits[pos];
        p.full = 1'b0;
        p.fin  = (pos == 0);
        pairs.push_back(p);
      end
      while (pos >= 2) begin
        pos -= 2;
        p.hi   = digits[pos+1];
        p.lo   = digits[pos];
        p.full = 1'b1;
        p.fin  = (pos == 0);
        pairs.push_back(p);
      end
    end
  endtask

  // Offer one limb beat, with an occasional gap before it, and record what it should cause.
  task automatic send_limb(input logic [LimbW-1:0] limb, input logic last,
                           input bit typed, input digit_pair_t typed_pair);
    int unsigned gap;
    digit_pair_t pairs [$];
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    limb_i      <= limb;
    last_limb_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    limbs_sent++;
    convert_limb(limb, last, pairs);
    if (typed) begin
      expected_pairs.push_back(typed_pair);
    end else begin
      foreach (pairs[i]) expected_pairs.push_back(pairs[i]);
    end
  endtask

  task automatic add_row(input logic [LimbW-1:0] limb, input logic last, input bit typed,
                         input logic [DigitW-1:0] hi, input logic [DigitW-1:0] lo,
                         input logic full, input logic fin);
    limb_row_t r;
    r.limb      = limb;
    r.last      = last;
    r.typed     = typed;
    r.pair.hi   = hi;
    r.pair.lo   = lo;
    r.pair.full = full;
    r.pair.fin  = fin;
    limb_table.push_back(r);
  endtask

  // Random limb contents: wide, narrow, zero and all ones.
  function automatic logic [LimbW-1:0] pick_limb();
    logic [LimbW-1:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       w = '0;
      1:       w = '1;
      2:       w = LimbW'($urandom_range(0, 99));
      3:       w = w >> $urandom_range(1, 63);
      default: ;
    endcase
    return w;
  endfunction

  task automatic wait_drained();
    while (expected_pairs.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: stalls in short bursts while idling is allowed.
  always @(negedge clk_i) begin
    if (!rst_ni || idle_pct == 0) begin
      out_ready_i <= 1'b1;
      stall_left  <= 0;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(0, 99) < idle_pct / 2) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 5);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Check each digit beat against the oldest expected pair.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_pair = {high_digit_o, low_digit_o, pair_full_o, last_pair_o};
      if (expected_pairs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: hi %0d lo %0d full %0b last %0b",
                   got_pair.hi, got_pair.lo, got_pair.full, got_pair.fin);
      end else begin
        want_pair = expected_pairs.pop_front();
        if (got_pair.hi !== want_pair.hi || got_pair.lo !== want_pair.lo ||
            got_pair.full !== want_pair.full || got_pair.fin !== want_pair.fin) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat mismatch: expected %p, got %p", want_pair, got_pair);
        end
      end
    end
  end

  // Main sequence: reset, directed table, random values, drain and verdict.
  initial begin
    int unsigned nlimbs;
    digit_pair_t none;
    none = '0;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Small values, whose pairs can be read off directly.
    add_row(64'd0,   1'b1, 1'b1, 4'd0, 4'd0, 1'b0, 1'b1);
    add_row(64'd9,   1'b1, 1'b1, 4'd0, 4'd9, 1'b0, 1'b1);
    add_row(64'd10,  1'b1, 1'b1, 4'd1, 4'd0, 1'b1, 1'b1);
    add_row(64'd99,  1'b1, 1'b1, 4'd9, 4'd9, 1'b1, 1'b1);
    add_row(64'd100, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
    // Extremes of a single limb.
    add_row('1, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row(64'h8000_0000_0000_0000, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
    // Largest value: all four limbs set, the longest digit string.
    add_row('1, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row('1, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row('1, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row('1, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
    // Two limbs only: the missing high limbs read as zero.
    add_row(64'd1, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row(64'd0, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
    // Five limbs: the oldest one falls out at the top.
    add_row('1,   1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row(64'd0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row(64'd0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row(64'd0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row(64'd5, 1'b1, 1'b1, 4'd0, 4'd5, 1'b0, 1'b1);
    // Four zero limbs still give a single zero digit.
    add_row(64'd0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row(64'd0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row(64'd0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row(64'd0, 1'b1, 1'b1, 4'd0, 4'd0, 1'b0, 1'b1);

    foreach (limb_table[i])
      send_limb(limb_table[i].limb, limb_table[i].last, limb_table[i].typed, limb_table[i].pair);

    // Hold the sender back until every pair of the directed part has come out.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_drained();

    // Random values of one to six limbs; more than four drop the oldest bits.
    while (limbs_sent < ITEM_TARGET) begin
      if (limbs_sent >= CALM_FROM) idle_pct = 0;
      else if (limbs_sent >= 120 && limbs_sent < 160) idle_pct = 0;
      else idle_pct = 30;
      if (limbs_sent >= 200 && limbs_sent < 206) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        wait_drained();
      end
      nlimbs = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
      for (int unsigned k = 1; k <= nlimbs; k++)
        send_limb(pick_limb(), (k == nlimbs), 1'b0, none);
    end

    @(negedge clk_i);
    in_valid_i  <= 1'b0;
    last_limb_i <= 1'b0;
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

### files.f
sv/b2d256_pkg.sv
sv/binary_to_decimal_256_top.sv
tb/tb_top.sv
